FILE: sv/dsched_pkg.sv
`timescale 1ns / 1ps

package dsched_pkg;

    typedef logic [1:0] policy_t;

    localparam policy_t POL_FCFS  = 2'd0;
    localparam policy_t POL_SSTF  = 2'd1;
    localparam policy_t POL_CSCAN = 2'd2;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] block_number;
        logic        is_write;
        logic [7:0]  requester_tag;
        logic [15:0] buffer_ref;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        queue_full;
        logic [15:0] chosen_block;
        logic        chosen_write;
        logic [7:0]  chosen_tag;
        logic [15:0] chosen_buffer;
        logic [15:0] seek_distance;
        logic [31:0] total_travel_out;
        logic [4:0]  pending_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/disk_request_scheduler.sv
// flow: an accepted word moves through the scan, apply and emit states, and its result
// word is registered on emit; enqueue and first come first served dispatch do no table
// scan, while shortest seek and circular scan dispatch scan one entry per cycle past the oldest
// throughput: one word in flight; the next word is taken while a result waits to be read
// reset: rst_n clears the table count, head, travel counter, policy and output valid
`timescale 1ns / 1ps

module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int BLOCK_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  dsched_pkg::req_t    req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output dsched_pkg::rsp_t    rsp_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dsched_pkg::policy_t cfg_data
);
    import dsched_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dsched_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dsched_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

    a_full_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.queue_full) |-> !rsp_word.accepted)
        else $error("dropped request reported as stored");

    a_no_choice_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_word.accepted) |->
            (rsp_word.chosen_block == '0) && (rsp_word.seek_distance == '0))
        else $error("chosen fields set without a dispatched request");

    a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid || !rsp_stall))
        else $error("result word overwritten while stalled");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply || cmd.scan_step) |-> req_stall)
        else $error("request taken while a word is in progress");

endmodule

FILE: sv/dsched_ctrl.sv
`timescale 1ns / 1ps

module dsched_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  dsched_pkg::dp_status_t status,
    output dsched_pkg::ctrl_cmd_t  cmd
);
    import dsched_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall     = 1'b1;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !status.scan_done;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: sv/dsched_dp.sv
`timescale 1ns / 1ps

module dsched_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int BLOCK_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dsched_pkg::req_t       req_word,
    input  logic                   cfg_valid,
    input  dsched_pkg::policy_t    cfg_data,
    input  dsched_pkg::ctrl_cmd_t  cmd,
    output dsched_pkg::dp_status_t status,
    input  logic                   rsp_stall,
    output logic                   rsp_valid,
    output dsched_pkg::rsp_t       rsp_word
);
    import dsched_pkg::*;

    localparam int BLK_W = (BLOCK_BITS < 16) ? BLOCK_BITS : 16;
    localparam int IW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [BLK_W-1:0] blk_dist(input logic [BLK_W-1:0] a,
                                                  input logic [BLK_W-1:0] b);
        blk_dist = (a >= b) ? (a - b) : (b - a);
    endfunction

    // request table, kept in arrival order
    logic [BLK_W-1:0] blk_mem [QUEUE_DEPTH];
    logic             wr_mem  [QUEUE_DEPTH];
    logic [7:0]       tag_mem [QUEUE_DEPTH];
    logic [15:0]      buf_mem [QUEUE_DEPTH];

    req_t             req_reg;
    policy_t          policy_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [BLK_W-1:0] head_reg;
    logic [BLK_W-1:0] head_next;
    logic [31:0]      travel_reg;
    logic [31:0]      travel_next;

    logic [CW-1:0]    idx_reg;
    logic [IW-1:0]    sstf_idx_reg;
    logic [BLK_W-1:0] sstf_dist_reg;
    logic             have_ahead_reg;
    logic [IW-1:0]    ahead_idx_reg;
    logic [BLK_W-1:0] ahead_blk_reg;
    logic [IW-1:0]    low_idx_reg;
    logic [BLK_W-1:0] low_blk_reg;

    rsp_t             res_reg;
    rsp_t             res_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_word_reg;

    logic [IW-1:0]    pick_idx;
    logic [IW-1:0]    rd_addr;
    logic [BLK_W-1:0] rd_blk;
    logic [BLK_W-1:0] rd_dist;
    logic             scan_active;
    logic             is_full;
    logic             do_enqueue;
    logic             do_dispatch;
    logic [32:0]      travel_sum;

    always_comb
    begin
        case (policy_reg)
            POL_SSTF:  pick_idx = sstf_idx_reg;
            POL_CSCAN: pick_idx = have_ahead_reg ? ahead_idx_reg : low_idx_reg;
            default:   pick_idx = '0;
        endcase
    end

    // one block-number read port, shared by the scan and the removal
    assign rd_addr = cmd.apply ? pick_idx : idx_reg[IW-1:0];
    assign rd_blk  = blk_mem[rd_addr];
    assign rd_dist = blk_dist(rd_blk, head_reg);

    assign scan_active = (req_reg.cmd == CMD_DISPATCH)
                         && ((policy_reg == POL_SSTF) || (policy_reg == POL_CSCAN));
    assign status.scan_done = !scan_active || (idx_reg >= count_reg);
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    assign is_full     = (count_reg == CW'(QUEUE_DEPTH));
    assign do_enqueue  = (req_reg.cmd == CMD_ENQUEUE) && !is_full;
    assign do_dispatch = (req_reg.cmd == CMD_DISPATCH) && (count_reg != '0);
    assign travel_sum  = {1'b0, travel_reg} + 33'(rd_dist);

    always_comb
    begin
        res_next    = '0;
        count_next  = count_reg;
        head_next   = head_reg;
        travel_next = travel_reg;
        if (req_reg.cmd == CMD_ENQUEUE)
        begin
            if (is_full)
            begin
                res_next.queue_full = 1'b1;
            end
            else
            begin
                res_next.accepted = 1'b1;
                count_next        = count_reg + 1'b1;
            end
        end
        else if (do_dispatch)
        begin
            res_next.accepted      = 1'b1;
            res_next.chosen_block  = 16'(rd_blk);
            res_next.chosen_write  = wr_mem[pick_idx];
            res_next.chosen_tag    = tag_mem[pick_idx];
            res_next.chosen_buffer = buf_mem[pick_idx];
            res_next.seek_distance = 16'(rd_dist);
            count_next             = count_reg - 1'b1;
            head_next              = rd_blk;
            travel_next            = travel_sum[32] ? '1 : travel_sum[31:0];
        end
        res_next.total_travel_out = travel_next;
        res_next.pending_count    = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FCFS;
            count_reg  <= '0;
            head_reg   <= '0;
            travel_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= cfg_data;
            end
            if (cmd.apply)
            begin
                count_reg  <= count_next;
                head_reg   <= head_next;
                travel_reg <= travel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            if (do_enqueue)
            begin
                blk_mem[count_reg[IW-1:0]] <= req_reg.block_number[BLK_W-1:0];
                wr_mem[count_reg[IW-1:0]]  <= req_reg.is_write;
                tag_mem[count_reg[IW-1:0]] <= req_reg.requester_tag;
                buf_mem[count_reg[IW-1:0]] <= req_reg.buffer_ref;
            end
            else if (do_dispatch)
            begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    if (IW'(i) >= pick_idx)
                    begin
                        blk_mem[i] <= blk_mem[i+1];
                        wr_mem[i]  <= wr_mem[i+1];
                        tag_mem[i] <= tag_mem[i+1];
                        buf_mem[i] <= buf_mem[i+1];
                    end
                end
            end
        end
    end

    // scan state, seeded from the oldest entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg        <= req_word;
            idx_reg        <= CW'(1);
            sstf_idx_reg   <= '0;
            sstf_dist_reg  <= blk_dist(blk_mem[0], head_reg);
            have_ahead_reg <= (blk_mem[0] >= head_reg);
            ahead_idx_reg  <= '0;
            ahead_blk_reg  <= blk_mem[0];
            low_idx_reg    <= '0;
            low_blk_reg    <= blk_mem[0];
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (rd_dist < sstf_dist_reg)
            begin
                sstf_dist_reg <= rd_dist;
                sstf_idx_reg  <= idx_reg[IW-1:0];
            end
            if ((rd_blk >= head_reg) && (!have_ahead_reg || (rd_blk < ahead_blk_reg)))
            begin
                have_ahead_reg <= 1'b1;
                ahead_blk_reg  <= rd_blk;
                ahead_idx_reg  <= idx_reg[IW-1:0];
            end
            if (rd_blk < low_blk_reg)
            begin
                low_blk_reg <= rd_blk;
                low_idx_reg <= idx_reg[IW-1:0];
            end
        end
        if (cmd.apply)
        begin
            res_reg <= res_next;
        end
        if (cmd.emit)
        begin
            rsp_word_reg <= res_reg;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
